// ===== design/g2t_pkg.sv =====
package g2t_pkg;

    // field widths
    localparam int CODE_W  = 7;
    localparam int POS_W   = 8;
    localparam int ADDR_W  = 12;
    localparam int MASK_W  = 8;
    localparam int TW_W    = 6;
    localparam int INK_W   = 2;
    localparam int CUR_W   = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // glyph geometry
    localparam int GLYPH_COLS = 3;
    localparam int GLYPH_ROWS = 6;
    localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
    localparam int FONT_DEPTH = 96;

    localparam logic [CODE_W-1:0] FIRST_CODE = 7'd32;
    localparam logic [CUR_W-1:0]  ADVANCE    = 10'd4;
    localparam logic [CUR_W-1:0]  CURSOR_MAX = 10'd1023;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILES_WIDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR  = 1'd1;

    localparam logic [TW_W-1:0]  TILES_WIDE_RST = 6'd10;
    localparam logic [INK_W-1:0] INK_COLOR_RST  = 2'd3;

    // parameter defaults
    localparam int STORE_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    // one character as it waits between front and back
    typedef struct packed {
        logic [GLYPH_BITS-1:0] keep;     // bit col*6+row, set pixels that land in the store
        logic [14:0]           rowbase;  // (y/8)*tiles_wide*16 of the top tile row
        logic [9:0]            tw16;     // tiles_wide*16, one tile row further down
        logic [2:0]            y_lo;     // y % 8 of the top pixel row
        logic [CUR_W-1:0]      x0;       // left pixel column
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // each entry: column bytes 0,1,2 from the top byte down, bit r = row r
    localparam logic [23:0] FONT [FONT_DEPTH] = '{
        24'h000000, 24'h001700, 24'h030003, 24'h1F0A1F,
        24'h161F0D, 24'h190413, 24'h1A150A, 24'h000300,
        24'h0E1100, 24'h00110E, 24'h0A040A, 24'h040E04,
        24'h100800, 24'h040404, 24'h001000, 24'h180403,
        24'h1F111F, 24'h121F10, 24'h1D1517, 24'h11151F,
        24'h07041F, 24'h17151D, 24'h1F151D, 24'h190503,
        24'h1F151F, 24'h17151F, 24'h000A00, 24'h100A00,
        24'h040A11, 24'h0A0A0A, 24'h110A04, 24'h011503,
        24'h0E1116, 24'h1F051F, 24'h1F151B, 24'h0E1111,
        24'h1F110E, 24'h1F1515, 24'h1F0505, 24'h0E111D,
        24'h1F041F, 24'h111F11, 24'h08110F, 24'h1F041B,
        24'h1F1010, 24'h1F021F, 24'h1F011E, 24'h0E110E,
        24'h1F0506, 24'h0E191F, 24'h1F051B, 24'h121509,
        24'h011F01, 24'h0F101F, 24'h0F100F, 24'h1F0C1F,
        24'h1B041B, 24'h031C03, 24'h191513, 24'h001F11,
        24'h030418, 24'h111F00, 24'h020102, 24'h101010,
        24'h010200, 24'h0C121E, 24'h1F120C, 24'h0C1212,
        24'h0C121F, 24'h0C1A16, 24'h1E0902, 24'h242A1E,
        24'h1F0418, 24'h001D00, 24'h20201D, 24'h1F041A,
        24'h000F10, 24'h1E041E, 24'h1E021C, 24'h0C120C,
        24'h3E0A04, 24'h040A3E, 24'h1E0402, 24'h14161A,
        24'h020F12, 24'h0E101E, 24'h0E100E, 24'h1E081E,
        24'h1A041A, 24'h26281E, 24'h1A1E16, 24'h041F11,
        24'h001F00, 24'h111F04, 24'h010302, 24'h0E090E
    };

    // pixel mask of a code, bit col*6+row; codes below the font draw blank
    function automatic logic [GLYPH_BITS-1:0] glyph_mask(logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] idx;
        logic [23:0]       e;
        if (code < FIRST_CODE) begin
            return '0;
        end
        idx = code - FIRST_CODE;
        e   = FONT[idx];
        return {e[5:0], e[13:8], e[21:16]};
    endfunction

    // low-plane byte address of one glyph pixel
    function automatic logic [15:0] pix_addr(t_job j, logic [1:0] col, logic [2:0] row);
        logic [3:0]  ys;
        logic [15:0] rb;
        logic [10:0] px;
        ys = {1'b0, j.y_lo} + {1'b0, row};
        rb = {1'b0, j.rowbase} + (ys[3] ? {6'b0, j.tw16} : 16'd0);
        px = {1'b0, j.x0} + {9'b0, col};
        return rb + {12'b0, ys[2:0], 1'b0} + {4'b0, px[10:3], 4'b0};
    endfunction

endpackage

// ===== design/g2t_req_if.sv =====
interface g2t_req_if;
    logic                       valid;
    logic                       ready;
    logic [g2t_pkg::CODE_W-1:0] char_code;
    logic [g2t_pkg::POS_W-1:0]  x_pos;
    logic [g2t_pkg::POS_W-1:0]  y_pos;
    logic                       start_text;

    modport source (output valid, char_code, x_pos, y_pos, start_text, input ready);
    modport sink   (input valid, char_code, x_pos, y_pos, start_text, output ready);
endinterface

// ===== design/g2t_wr_if.sv =====
interface g2t_wr_if;
    logic                       valid;
    logic                       ready;
    logic [g2t_pkg::ADDR_W-1:0] byte_addr;
    logic [g2t_pkg::MASK_W-1:0] low_plane_mask;
    logic [g2t_pkg::MASK_W-1:0] high_plane_mask;
    logic                       last;

    modport source (output valid, byte_addr, low_plane_mask, high_plane_mask, last,
                    input ready);
    modport sink   (input valid, byte_addr, low_plane_mask, high_plane_mask, last,
                    output ready);
endinterface

// ===== design/glyph_to_tile_rasterizer_core.sv =====
// channel   | role   | carries
// ----------+--------+-----------------------------------------------------------
// i_req     | sink   | char_code, x_pos, y_pos, start_text: one character request
// o_wr      | source | byte_addr, low/high_plane_mask, last: one pixel tile write
// i_cfg_*   | write  | index 0 tiles_wide, index 1 ink_color
//
// one tile write per cycle while the output is not stalled: a character holds the raster
// stage until each of its kept pixels, up to 18, is written; one with none pops with no write
// a first write follows its request through the classify, queue and raster registers
// the front takes a new request every cycle while the queue has room
// synchronous active-low reset clears cursor, queue, valid flags, tiles_wide 10, ink 3
// a stalled write output holds the raster stage, the queue then fills and stalls requests
module glyph_to_tile_rasterizer_core #(
    parameter int STORE_BYTES = g2t_pkg::STORE_BYTES_DEF,
    parameter int QUEUE_DEPTH = g2t_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    g2t_req_if.sink                        i_req,
    g2t_wr_if.source                       o_wr,
    input  logic                           i_cfg_we,
    input  logic [g2t_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [g2t_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [g2t_pkg::TW_W-1:0]  r_tiles_wide;
    logic [g2t_pkg::INK_W-1:0] r_ink;

    // front to queue, queue to back
    logic              q_push;
    logic              q_pop;
    g2t_pkg::t_job     q_in;
    g2t_pkg::t_job     q_head;
    g2t_pkg::t_q_stat  q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles_wide <= g2t_pkg::TILES_WIDE_RST;
            r_ink        <= g2t_pkg::INK_COLOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                g2t_pkg::CFG_TILES_WIDE: begin
                    r_tiles_wide <= i_cfg_data;
                end
                g2t_pkg::CFG_INK_COLOR: begin
                    r_ink <= i_cfg_data[g2t_pkg::INK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // accept, glyph lookup, cursor, tile row base, store range filter
    g2t_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_tiles_wide (r_tiles_wide),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_job        (q_in)
    );

    // short queue so classify and raster stall on their own
    g2t_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // one kept pixel a cycle, while the output is not stalled, into the registered write output
    g2t_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q_stat (q_stat),
        .i_ink    (r_ink),
        .o_pop    (q_pop),
        .o_wr     (o_wr)
    );

    // no push into a full queue, no pop from an empty one
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_push |-> !q_stat.full)
        else $error("queue push while full");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // plane masks follow the ink colour
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid |-> (((o_wr.low_plane_mask != '0) == r_ink[0]) &&
                        ((o_wr.high_plane_mask != '0) == r_ink[1])))
        else $error("plane mask disagrees with ink colour");

    // low-plane address is even and one pixel bit at most
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid |-> (!o_wr.byte_addr[0] && $onehot0(o_wr.low_plane_mask)))
        else $error("malformed tile write");

endmodule

// ===== design/g2t_front.sv =====
module g2t_front #(
    parameter int STORE_BYTES = g2t_pkg::STORE_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    g2t_req_if.sink                  i_req,
    input  logic [g2t_pkg::TW_W-1:0] i_tiles_wide,
    input  g2t_pkg::t_q_stat         i_q_stat,
    output logic                     o_push,
    output g2t_pkg::t_job            o_job
);

    localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);

    logic                              r_a_valid;
    logic [g2t_pkg::GLYPH_BITS-1:0]    r_a_glyph;
    g2t_pkg::t_job                     r_a_job;
    logic [g2t_pkg::CUR_W-1:0]         r_cursor;
    logic [g2t_pkg::CUR_W-1:0]         n_cursor;
    logic [g2t_pkg::CUR_W-1:0]         x0;
    logic [g2t_pkg::CUR_W:0]           x_next;
    logic [10:0]                       rb_prod;
    logic                              accept;
    logic [15:0]                       addr;

    assign accept       = i_req.valid && i_req.ready;
    assign i_req.ready  = !r_a_valid || !i_q_stat.full;
    assign o_push       = r_a_valid && !i_q_stat.full;

    // draw position and cursor advance
    assign x0       = i_req.start_text ? {2'b0, i_req.x_pos} : r_cursor;
    assign x_next   = {1'b0, x0} + {1'b0, g2t_pkg::ADVANCE};
    assign n_cursor = x_next[g2t_pkg::CUR_W] ? g2t_pkg::CURSOR_MAX : x_next[g2t_pkg::CUR_W-1:0];
    assign rb_prod  = 11'(i_req.y_pos[7:3] * i_tiles_wide);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_cursor  <= '0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_cursor  <= n_cursor;
            end else if (o_push) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_glyph       <= g2t_pkg::glyph_mask(i_req.char_code);
            r_a_job.keep    <= '0;
            r_a_job.rowbase <= {rb_prod, 4'b0};
            r_a_job.tw16    <= {i_tiles_wide, 4'b0};
            r_a_job.y_lo    <= i_req.y_pos[2:0];
            r_a_job.x0      <= x0;
        end
    end

    // drop pixels whose byte pair falls outside the store
    always_comb begin
        o_job      = r_a_job;
        o_job.keep = '0;
        addr       = '0;
        for (int c = 0; c < g2t_pkg::GLYPH_COLS; c++) begin
            for (int r = 0; r < g2t_pkg::GLYPH_ROWS; r++) begin
                addr = g2t_pkg::pix_addr(r_a_job, 2'(c), 3'(r));
                o_job.keep[c*g2t_pkg::GLYPH_ROWS+r] =
                    r_a_glyph[c*g2t_pkg::GLYPH_ROWS+r] && (({1'b0, addr} + 17'd1) < STORE_LIM);
            end
        end
    end

endmodule

// ===== design/g2t_queue.sv =====
module g2t_queue #(
    parameter int DEPTH = g2t_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  g2t_pkg::t_job     i_job,
    input  logic              i_pop,
    output g2t_pkg::t_job     o_head,
    output g2t_pkg::t_q_stat  o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    g2t_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/g2t_back.sv =====
module g2t_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  g2t_pkg::t_job             i_head,
    input  g2t_pkg::t_q_stat          i_q_stat,
    input  logic [g2t_pkg::INK_W-1:0] i_ink,
    output logic                      o_pop,
    g2t_wr_if.source                  o_wr
);

    logic [g2t_pkg::GLYPH_BITS-1:0] r_done;
    logic [g2t_pkg::GLYPH_BITS-1:0] avail;
    logic [g2t_pkg::GLYPH_BITS-1:0] pick_bit;
    logic [1:0]                     pick_col;
    logic [2:0]                     pick_row;
    logic                           r_o_valid;
    logic [g2t_pkg::ADDR_W-1:0]     r_o_addr;
    logic [g2t_pkg::MASK_W-1:0]     r_o_low;
    logic [g2t_pkg::MASK_W-1:0]     r_o_high;
    logic                           r_o_last;
    logic                           adv;
    logic                           emit;
    logic                           blank;
    logic                           is_last;
    logic [15:0]                    addr;
    logic [2:0]                     px_lo;
    logic [g2t_pkg::MASK_W-1:0]     bit_mask;

    assign avail = i_head.keep & ~r_done;

    // lowest pending pixel: column first, then row
    always_comb begin
        pick_col = '0;
        pick_row = '0;
        pick_bit = '0;
        for (int c = g2t_pkg::GLYPH_COLS - 1; c >= 0; c--) begin
            for (int r = g2t_pkg::GLYPH_ROWS - 1; r >= 0; r--) begin
                if (avail[c*g2t_pkg::GLYPH_ROWS+r]) begin
                    pick_col = 2'(c);
                    pick_row = 3'(r);
                    pick_bit = '0;
                    pick_bit[c*g2t_pkg::GLYPH_ROWS+r] = 1'b1;
                end
            end
        end
    end

    assign adv      = !r_o_valid || o_wr.ready;
    assign blank    = !i_q_stat.empty && (avail == '0);
    assign emit     = !i_q_stat.empty && (avail != '0) && adv;
    assign is_last  = ((avail & ~pick_bit) == '0);
    assign o_pop    = blank || (emit && is_last);

    assign addr     = g2t_pkg::pix_addr(i_head, pick_col, pick_row);
    assign px_lo    = 3'(i_head.x0[2:0] + {1'b0, pick_col});
    assign bit_mask = 8'h80 >> px_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_done <= '0;
            end else if (emit) begin
                r_done <= r_done | pick_bit;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (o_wr.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_addr <= addr[g2t_pkg::ADDR_W-1:0];
            r_o_low  <= i_ink[0] ? bit_mask : '0;
            r_o_high <= i_ink[1] ? bit_mask : '0;
            r_o_last <= is_last;
        end
    end

    assign o_wr.valid           = r_o_valid;
    assign o_wr.byte_addr       = r_o_addr;
    assign o_wr.low_plane_mask  = r_o_low;
    assign o_wr.high_plane_mask = r_o_high;
    assign o_wr.last            = r_o_last;

endmodule

// ===== tb/tb_glyph_to_tile_rasterizer_core.sv =====
module tb_glyph_to_tile_rasterizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int STORE_BYTES   = 4096;
    // worst case: every character at 18 writes, each write behind the longest stall,
    // plus the longest request gaps, taken about four times over
    localparam int CYCLE_LIMIT   = 1_000_000;
    // a request passes the front register, the queue and the output register, and blank
    // characters still in the queue drain too, so this covers anything left in flight once no write is owed
    localparam int DRAIN_CYCLES  = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS   = 150;

    // font columns, three bytes per code from 32 upwards; bit r of a byte is pixel row r
    localparam logic [7:0] FONT_COLS [288] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h17, 8'h00, 8'h03, 8'h00, 8'h03, 8'h1F, 8'h0A, 8'h1F,
        8'h16, 8'h1F, 8'h0D, 8'h19, 8'h04, 8'h13, 8'h1A, 8'h15, 8'h0A, 8'h00, 8'h03, 8'h00,
        8'h0E, 8'h11, 8'h00, 8'h00, 8'h11, 8'h0E, 8'h0A, 8'h04, 8'h0A, 8'h04, 8'h0E, 8'h04,
        8'h10, 8'h08, 8'h00, 8'h04, 8'h04, 8'h04, 8'h00, 8'h10, 8'h00, 8'h18, 8'h04, 8'h03,
        8'h1F, 8'h11, 8'h1F, 8'h12, 8'h1F, 8'h10, 8'h1D, 8'h15, 8'h17, 8'h11, 8'h15, 8'h1F,
        8'h07, 8'h04, 8'h1F, 8'h17, 8'h15, 8'h1D, 8'h1F, 8'h15, 8'h1D, 8'h19, 8'h05, 8'h03,
        8'h1F, 8'h15, 8'h1F, 8'h17, 8'h15, 8'h1F, 8'h00, 8'h0A, 8'h00, 8'h10, 8'h0A, 8'h00,
        8'h04, 8'h0A, 8'h11, 8'h0A, 8'h0A, 8'h0A, 8'h11, 8'h0A, 8'h04, 8'h01, 8'h15, 8'h03,
        8'h0E, 8'h11, 8'h16, 8'h1F, 8'h05, 8'h1F, 8'h1F, 8'h15, 8'h1B, 8'h0E, 8'h11, 8'h11,
        8'h1F, 8'h11, 8'h0E, 8'h1F, 8'h15, 8'h15, 8'h1F, 8'h05, 8'h05, 8'h0E, 8'h11, 8'h1D,
        8'h1F, 8'h04, 8'h1F, 8'h11, 8'h1F, 8'h11, 8'h08, 8'h11, 8'h0F, 8'h1F, 8'h04, 8'h1B,
        8'h1F, 8'h10, 8'h10, 8'h1F, 8'h02, 8'h1F, 8'h1F, 8'h01, 8'h1E, 8'h0E, 8'h11, 8'h0E,
        8'h1F, 8'h05, 8'h06, 8'h0E, 8'h19, 8'h1F, 8'h1F, 8'h05, 8'h1B, 8'h12, 8'h15, 8'h09,
        8'h01, 8'h1F, 8'h01, 8'h0F, 8'h10, 8'h1F, 8'h0F, 8'h10, 8'h0F, 8'h1F, 8'h0C, 8'h1F,
        8'h1B, 8'h04, 8'h1B, 8'h03, 8'h1C, 8'h03, 8'h19, 8'h15, 8'h13, 8'h00, 8'h1F, 8'h11,
        8'h03, 8'h04, 8'h18, 8'h11, 8'h1F, 8'h00, 8'h02, 8'h01, 8'h02, 8'h10, 8'h10, 8'h10,
        8'h01, 8'h02, 8'h00, 8'h0C, 8'h12, 8'h1E, 8'h1F, 8'h12, 8'h0C, 8'h0C, 8'h12, 8'h12,
        8'h0C, 8'h12, 8'h1F, 8'h0C, 8'h1A, 8'h16, 8'h1E, 8'h09, 8'h02, 8'h24, 8'h2A, 8'h1E,
        8'h1F, 8'h04, 8'h18, 8'h00, 8'h1D, 8'h00, 8'h20, 8'h20, 8'h1D, 8'h1F, 8'h04, 8'h1A,
        8'h00, 8'h0F, 8'h10, 8'h1E, 8'h04, 8'h1E, 8'h1E, 8'h02, 8'h1C, 8'h0C, 8'h12, 8'h0C,
        8'h3E, 8'h0A, 8'h04, 8'h04, 8'h0A, 8'h3E, 8'h1E, 8'h04, 8'h02, 8'h14, 8'h16, 8'h1A,
        8'h02, 8'h0F, 8'h12, 8'h0E, 8'h10, 8'h1E, 8'h0E, 8'h10, 8'h0E, 8'h1E, 8'h08, 8'h1E,
        8'h1A, 8'h04, 8'h1A, 8'h26, 8'h28, 8'h1E, 8'h1A, 8'h1E, 8'h16, 8'h04, 8'h1F, 8'h11,
        8'h00, 8'h1F, 8'h00, 8'h11, 8'h1F, 8'h04, 8'h01, 8'h03, 8'h02, 8'h0E, 8'h09, 8'h0E
    };

    // one pixel write as it should leave the block
    typedef struct packed {
        logic [g2t_pkg::ADDR_W-1:0] addr;
        logic [g2t_pkg::MASK_W-1:0] lo_mask;
        logic [g2t_pkg::MASK_W-1:0] hi_mask;
        logic                       last;
    } t_tile_write;

    // one character request, with the register setting it is drawn under; rows marked
    // typed carry their single write (or none) spelt out instead of predicted
    typedef struct packed {
        logic [g2t_pkg::CODE_W-1:0] code;
        logic [g2t_pkg::POS_W-1:0]  x;
        logic [g2t_pkg::POS_W-1:0]  y;
        logic                       start;
        logic [g2t_pkg::TW_W-1:0]   tw;
        logic [g2t_pkg::INK_W-1:0]  ink;
        logic                       typed;
        logic [1:0]                 n_typed;
        logic [g2t_pkg::ADDR_W-1:0] t_addr;
        logic [g2t_pkg::MASK_W-1:0] t_lo;
        logic [g2t_pkg::MASK_W-1:0] t_hi;
    } t_glyph_row;

    // one random stretch under a fixed register setting
    typedef struct packed {
        logic [g2t_pkg::TW_W-1:0]  tw;
        logic [g2t_pkg::INK_W-1:0] ink;
        logic [8:0]                count;
        logic [6:0]                start_pct;
        logic [7:0]                y_max;
        logic                      cursor_run;
    } t_phase;

    //       code  x    y    st tw  ink typ n  addr  lo     hi
    localparam t_glyph_row DIRECTED_ROWS [21] = '{
        // lowest code is blank, cursor still steps on from reset
        '{0,   0,   0,   0, 10, 3,  1,  0, 0,    0,     0},
        // highest blank code, start at the far corner
        '{31,  255, 255, 1, 10, 3,  1,  0, 0,    0,     0},
        // full stop: one pixel at column 1, row 4
        '{46,  0,   0,   1, 10, 3,  1,  1, 8,    8'h40, 8'h40},
        // pixel column 256 sits at the left edge of tile 32
        '{46,  255, 0,   1, 10, 3,  1,  1, 520,  8'h80, 8'h80},
        // bottom edge: whole glyph falls past the store and is dropped
        '{46,  255, 255, 1, 10, 3,  1,  0, 0,    0,     0},
        // space, first code of the font, draws nothing
        '{32,  7,   7,   1, 10, 3,  0,  0, 0,    0,     0},
        // last code of the font, drawn at the cursor
        '{127, 0,   0,   0, 10, 3,  0,  0, 0,    0,     0},
        // the densest glyph
        '{56,  0,   100, 0, 10, 3,  0,  0, 0,    0,     0},
        // glyph straddling a tile row
        '{35,  0,   5,   0, 10, 3,  0,  0, 0,    0,     0},
        // first column kept, the other two land past the store
        '{56,  47,  200, 1, 10, 3,  0,  0, 0,    0,     0},
        // descender on the sixth row
        '{103, 0,   60,  0, 10, 3,  0,  0, 0,    0,     0},
        '{124, 0,   0,   0, 10, 3,  0,  0, 0,    0,     0},
        '{1,   200, 9,   0, 10, 3,  0,  0, 0,    0,     0},
        '{95,  128, 255, 1, 10, 3,  0,  0, 0,    0,     0},
        // no ink: the write still comes out, both masks clear
        '{46,  0,   0,   1, 0,  0,  1,  1, 8,    0,     0},
        // zero row stride: tile row 2 folds back onto row 0
        '{46,  0,   12,  1, 0,  2,  1,  1, 0,    0,     8'h40},
        '{56,  0,   7,   0, 0,  2,  0,  0, 0,    0,     0},
        // widest stride the register holds
        '{46,  8,   8,   1, 63, 1,  1,  1, 1032, 8'h40, 0},
        '{127, 255, 30,  1, 63, 1,  0,  0, 0,    0,     0},
        '{65,  0,   0,   0, 32, 3,  0,  0, 0,    0,     0},
        '{46,  255, 6,   1, 32, 3,  1,  1, 1028, 8'h80, 8'h80}
    };

    localparam t_phase PHASES [5] = '{
        '{1,  1, 24,  30, 255, 0},
        '{32, 2, 20,  30, 255, 0},
        '{0,  0, 15,  40, 255, 0},
        '{63, 3, 20,  40, 40,  0},
        // long run on the cursor alone, far enough to pin it at its ceiling
        '{10, 1, 215, 0,  60,  1}
    };

    logic i_clk;
    logic i_rst_n;
    logic                           i_cfg_we;
    logic [g2t_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [g2t_pkg::CFG_DATA_W-1:0] i_cfg_data;

    g2t_req_if req_ch ();
    g2t_wr_if  wr_ch ();

    glyph_to_tile_rasterizer_core #(
        .STORE_BYTES (STORE_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_wr       (wr_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block: registers, text cursor, and the writes still owed
    logic [g2t_pkg::TW_W-1:0]  model_tw;
    logic [g2t_pkg::INK_W-1:0] model_ink;
    logic [g2t_pkg::CUR_W-1:0] model_cursor;
    t_tile_write               glyph_writes [g2t_pkg::GLYPH_BITS];
    int                        glyph_count;
    t_tile_write               pending_writes [$];

    int  cycle_count   = 0;
    int  err_count     = 0;
    int  chars_sent    = 0;
    int  writes_seen   = 0;
    int  settings_used = 0;
    logic req_calm     = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // rasterise one character into glyph_writes and step the cursor
    function automatic void plot_char(input logic [g2t_pkg::CODE_W-1:0] code,
                                      input logic [g2t_pkg::POS_W-1:0]  x,
                                      input logic [g2t_pkg::POS_W-1:0]  y,
                                      input logic                       start);
        int          left, px, py, addr, base, c, r;
        logic [7:0]  colbits, bitmask;
        t_tile_write wr;
        left = start ? int'(x) : int'(model_cursor);
        // cursor sticks at its ceiling
        if (left + int'(g2t_pkg::ADVANCE) > int'(g2t_pkg::CURSOR_MAX)) begin
            model_cursor = g2t_pkg::CURSOR_MAX;
        end else begin
            model_cursor = g2t_pkg::CUR_W'(left + int'(g2t_pkg::ADVANCE));
        end
        glyph_count = 0;
        if (code >= g2t_pkg::FIRST_CODE) begin
            base = (int'(code) - int'(g2t_pkg::FIRST_CODE)) * g2t_pkg::GLYPH_COLS;
            // column first, then rows top down
            for (c = 0; c < g2t_pkg::GLYPH_COLS; c++) begin
                colbits = FONT_COLS[base + c];
                for (r = 0; r < g2t_pkg::GLYPH_ROWS; r++) begin
                    if (colbits[r]) begin
                        px   = left + c;
                        py   = int'(y) + r;
                        addr = (py / 8) * int'(model_tw) * 16 + (py % 8) * 2 + (px / 8) * 16;
                        // the byte pair must sit wholly inside the store
                        if (addr + 1 < STORE_BYTES) begin
                            bitmask    = 8'h80 >> (px % 8);
                            wr.addr    = g2t_pkg::ADDR_W'(addr);
                            wr.lo_mask = model_ink[0] ? bitmask : 8'h00;
                            wr.hi_mask = model_ink[1] ? bitmask : 8'h00;
                            wr.last    = 1'b0;
                            glyph_writes[glyph_count] = wr;
                            glyph_count++;
                        end
                    end
                end
            end
        end
        // last flag goes on the final write that survives the store check
        if (glyph_count > 0) begin
            glyph_writes[glyph_count - 1].last = 1'b1;
        end
    endfunction

    // stop sending and wait until every owed write has come out
    task automatic drain_writes();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // write both registers while the block sits idle
    task automatic apply_setting(input logic [g2t_pkg::TW_W-1:0]  tw,
                                 input logic [g2t_pkg::INK_W-1:0] ink);
        drain_writes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= g2t_pkg::CFG_TILES_WIDE;
        i_cfg_data <= tw;
        @(posedge i_clk);
        // spare upper bits carry noise, ink_color only keeps its two
        i_cfg_idx  <= g2t_pkg::CFG_INK_COLOR;
        i_cfg_data <= {4'($urandom_range(0, 15)), ink};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model_tw  = tw;
        model_ink = ink;
        settings_used++;
    endtask

    // offer one request, wait for it to be taken, then book its writes
    task automatic send_char(input t_glyph_row row);
        int          gap, n;
        t_tile_write wr;
        gap = req_calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.char_code  <= row.code;
        req_ch.x_pos      <= row.x;
        req_ch.y_pos      <= row.y;
        req_ch.start_text <= row.start;
        do @(posedge i_clk); while (!req_ch.ready);
        // cursor moves for every request, typed or not
        plot_char(row.code, row.x, row.y, row.start);
        chars_sent++;
        if (row.typed) begin
            for (n = 0; n < int'(row.n_typed); n++) begin
                wr.addr    = row.t_addr;
                wr.lo_mask = row.t_lo;
                wr.hi_mask = row.t_hi;
                wr.last    = 1'b1;
                pending_writes.push_back(wr);
            end
        end else begin
            for (n = 0; n < glyph_count; n++) begin
                pending_writes.push_back(glyph_writes[n]);
            end
        end
        // flip in and out of stretches with no request gaps
        if ($urandom_range(0, 99) < 5) begin
            req_calm = ~req_calm;
        end
    endtask

    // write side: random back-pressure, with quiet stretches of none
    initial begin : write_sink
        int   hold;
        logic quiet;
        hold  = 0;
        quiet = 1'b0;
        wr_ch.ready = 1'b0;
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if ($urandom_range(0, 99) < 4) begin
                quiet = ~quiet;
            end
            if (hold > 0) begin
                wr_ch.ready <= 1'b0;
                hold--;
            end else begin
                wr_ch.ready <= 1'b1;
                if (!quiet) begin
                    hold = pick_gap();
                end
            end
            @(posedge i_clk);
        end
    end

    // every accepted write against the oldest one owed
    always @(posedge i_clk) begin : write_check
        t_tile_write want;
        if (i_rst_n && wr_ch.valid && wr_ch.ready) begin
            writes_seen++;
            if (pending_writes.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t: write with none owed: addr %0d lo %02h hi %02h last %0b",
                             $time, wr_ch.byte_addr, wr_ch.low_plane_mask,
                             wr_ch.high_plane_mask, wr_ch.last);
                end
            end else begin
                want = pending_writes.pop_front();
                if (wr_ch.byte_addr !== want.addr || wr_ch.low_plane_mask !== want.lo_mask ||
                    wr_ch.high_plane_mask !== want.hi_mask || wr_ch.last !== want.last) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: write mismatch: expected addr %0d lo %02h hi %02h last %0b",
                                 $time, want.addr, want.lo_mask, want.hi_mask, want.last);
                        $display("%0t: write mismatch: got addr %0d lo %02h hi %02h last %0b",
                                 $time, wr_ch.byte_addr, wr_ch.low_plane_mask,
                                 wr_ch.high_plane_mask, wr_ch.last);
                    end
                end
            end
        end
    end

    // hard stop if the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t: timeout after %0d cycles, %0d writes still owed",
                 $time, cycle_count, pending_writes.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_glyph_row row;
        t_phase     ph;
        int         k, p, pick;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.char_code  = '0;
        req_ch.x_pos      = '0;
        req_ch.y_pos      = '0;
        req_ch.start_text = 1'b0;
        model_tw          = g2t_pkg::TILES_WIDE_RST;
        model_ink         = g2t_pkg::INK_COLOR_RST;
        model_cursor      = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows, registers changed only where a row asks for another setting
        for (k = 0; k < $size(DIRECTED_ROWS); k++) begin
            row = DIRECTED_ROWS[k];
            if (row.tw != model_tw || row.ink != model_ink) begin
                apply_setting(row.tw, row.ink);
            end
            send_char(row);
        end

        // random stretches, one register setting each
        for (p = 0; p < $size(PHASES); p++) begin
            ph = PHASES[p];
            apply_setting(ph.tw, ph.ink);
            for (k = 0; k < int'(ph.count); k++) begin
                // halfway through, hold back until the block has caught up
                if (k == int'(ph.count) / 2) begin
                    drain_writes();
                end
                row  = '0;
                pick = $urandom_range(0, 99);
                row.code = (pick < 10) ? g2t_pkg::CODE_W'($urandom_range(0, 31))
                                       : g2t_pkg::CODE_W'($urandom_range(32, 127));
                row.x = g2t_pkg::POS_W'($urandom_range(0, 255));
                row.y = g2t_pkg::POS_W'($urandom_range(0, int'(ph.y_max)));
                if (ph.cursor_run) begin
                    // one anchored request far right, then the cursor on its own
                    row.start = (k == 0);
                    if (k == 0) begin
                        row.x = g2t_pkg::POS_W'($urandom_range(192, 255));
                    end
                end else begin
                    row.start = ($urandom_range(0, 99) < int'(ph.start_pct));
                end
                send_char(row);
            end
        end

        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d character requests (%0d directed) and %0d tile writes",
                 chars_sent, $size(DIRECTED_ROWS), writes_seen);
        $display("%0d register settings, strides 0 to 63 and every ink colour, cursor to its cap",
                 settings_used);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== glyph_to_tile_rasterizer_core.f =====
design/g2t_pkg.sv
design/g2t_req_if.sv
design/g2t_wr_if.sv
design/g2t_front.sv
design/g2t_queue.sv
design/g2t_back.sv
design/glyph_to_tile_rasterizer_core.sv
tb/tb_glyph_to_tile_rasterizer_core.sv
